// ===== hdl/sfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types for the stream find-and-replace-all block.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// default size limits for pattern and replacement
	localparam int unsigned MAX_PATTERN_LEN_DEF = 8;
	localparam int unsigned MAX_REPLACE_LEN_DEF = 8;

	// configuration register file geometry
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_ADDR_W = 5;
	localparam int unsigned CFG_LEN_W  = 4;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_PATTERN_BYTES     = 2'd0,
		REG_PATTERN_LENGTH    = 2'd1,
		REG_REPLACEMENT_BYTES = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

endpackage
`default_nettype wire

// ===== hdl/sfr_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_window
// Pending-byte window with match test; builds the result list for one byte.
// ----------------------------------------------------------------------------
module sfr_window import sfr_pkg::*; #(
	parameter int unsigned MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
	parameter int unsigned MAX_REPLACE_LEN = MAX_REPLACE_LEN_DEF,
	localparam int unsigned PW = $clog2(MAX_PATTERN_LEN + 1),
	localparam int unsigned RW = $clog2(MAX_REPLACE_LEN + 1),
	localparam int unsigned RES_DEPTH = (MAX_PATTERN_LEN > MAX_REPLACE_LEN) ?
		MAX_PATTERN_LEN : MAX_REPLACE_LEN,
	localparam int unsigned NW = $clog2(RES_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  in_final,
	input  wire logic [CFG_DATA_W-1:0] pat_bytes,
	input  wire logic [PW-1:0]         pat_len,
	input  wire logic [CFG_DATA_W-1:0] rep_bytes,
	input  wire logic [RW-1:0]         rep_len,
	output logic [7:0]                 res_byte [RES_DEPTH],
	output logic [NW-1:0]              res_n,
	output logic                       res_has
);

	localparam int unsigned P = MAX_PATTERN_LEN;

	logic [7:0]    win_q [P];
	logic [PW-1:0] fill_q;

	logic [7:0]    w [RES_DEPTH];
	logic [7:0]    win_next [P];
	logic [PW-1:0] fill1;
	logic [PW-1:0] keep;
	logic [PW-1:0] emit;
	logic [PW-1:0] start;
	logic          mismatch;
	logic          match;
	logic [PW:0]   pos;

	// window after the push of the new byte
	always_comb begin
		for (int i = 0; i < RES_DEPTH; i++) begin
			w[i] = 8'h00;
		end
		for (int i = 0; i < P; i++) begin
			w[i] = (fill_q == PW'(i)) ? in_byte : win_q[i];
		end
		fill1 = fill_q + PW'(1);
	end

	// match test over the pattern bytes in use
	always_comb begin
		mismatch = 1'b0;
		for (int i = 0; i < P; i++) begin
			if (PW'(i) < pat_len && w[i] != pat_bytes[8*i +: 8]) begin
				mismatch = 1'b1;
			end
		end
		match = (pat_len != '0) && (fill1 == pat_len) && !mismatch;
	end

	// how many window bytes leave this step
	always_comb begin
		keep  = (pat_len != '0) ? pat_len - PW'(1) : '0;
		emit  = (fill1 > keep) ? fill1 - keep : '0;
		start = (match || in_final) ? fill1 : emit;
	end

	// result list: replacement on a match, else the leaving window bytes
	always_comb begin
		res_has = 1'b1;
		for (int i = 0; i < RES_DEPTH; i++) begin
			res_byte[i] = match ? rep_bytes[8*i +: 8] : w[i];
		end
		res_n = match ? NW'(rep_len) : NW'(start);
		if (in_final && res_n == '0) begin
			// empty end marker
			res_has     = 1'b0;
			res_n       = NW'(1);
			res_byte[0] = 8'h00;
		end
	end

	// remaining bytes slide down to the front
	always_comb begin
		for (int i = 0; i < P; i++) begin
			win_next[i] = win_q[i];
			pos = {1'b0, start} + (PW + 1)'(i);
			for (int k = 0; k < P; k++) begin
				if (pos == (PW + 1)'(k)) begin
					win_next[i] = w[k];
				end
			end
		end
	end

	// window fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (adv) begin
			fill_q <= in_final ? '0 : fill1 - start;
		end
	end

	// window bytes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < P; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < PW'(P))
		else $error("window fill reached the window depth");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_final |=> fill_q == '0)
		else $error("window not empty after the last byte of a string");

	a_match_empties: assert property (@(posedge clk) disable iff (!arst_n)
		adv && match |=> fill_q == '0)
		else $error("window not empty after a replacement");
`endif

endmodule
`default_nettype wire

// ===== hdl/stream_find_replace_all.sv =====
`default_nettype none
// result path: a byte's first result passes the input register, then the result buffer,
//   and waits in the input register while the buffer still holds results
// throughput: one byte per cycle while each byte yields at most one result
//   and no output stall; a byte with k results holds the buffer until all are taken
// the output buffer drains one result per cycle unless stalled, which sets the rate
// reset: configuration clears to zero, window empty, no result pending
// ----------------------------------------------------------------------------
// stream_find_replace_all
// Replaces every leftmost non-overlapping pattern occurrence in a byte stream.
// ----------------------------------------------------------------------------
module stream_find_replace_all import sfr_pkg::*; #(
	parameter int unsigned MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
	parameter int unsigned MAX_REPLACE_LEN = MAX_REPLACE_LEN_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready,
	// input stream
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  in_final,
	// output stream
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 out_byte,
	output logic                       has_byte,
	output logic                       run_end,
	output logic                       string_end
);

	localparam int unsigned PW = $clog2(MAX_PATTERN_LEN + 1);
	localparam int unsigned RW = $clog2(MAX_REPLACE_LEN + 1);
	localparam int unsigned RES_DEPTH = (MAX_PATTERN_LEN > MAX_REPLACE_LEN) ?
		MAX_PATTERN_LEN : MAX_REPLACE_LEN;
	localparam int unsigned NW = $clog2(RES_DEPTH + 1);

	logic [CFG_DATA_W-1:0] pat_bytes_q;
	logic [CFG_LEN_W-1:0]  pat_len_q;
	logic [CFG_DATA_W-1:0] rep_bytes_q;
	logic [CFG_LEN_W-1:0]  rep_len_q;
	logic [PW-1:0]         pat_len;
	logic [RW-1:0]         rep_len;
	cfg_reg_t              reg_sel;
	logic                  cfg_wr;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  final_s1;

	logic [7:0]            res_byte [RES_DEPTH];
	logic [NW-1:0]         res_n;
	logic                  res_has;

	logic [7:0]            obuf_q [RES_DEPTH];
	logic [NW-1:0]         rem_q;
	logic                  has_q;
	logic                  fin_q;

	logic                  out_take;
	logic                  in_take;
	logic                  buf_free;
	logic                  adv;

	// configuration access
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q <= '0;
			pat_len_q   <= '0;
			rep_bytes_q <= '0;
			rep_len_q   <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_PATTERN_BYTES:      pat_bytes_q <= pwdata;
				REG_PATTERN_LENGTH:     pat_len_q   <= pwdata[CFG_LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  rep_bytes_q <= pwdata;
				REG_REPLACEMENT_LENGTH: rep_len_q   <= pwdata[CFG_LEN_W-1:0];
				default:                pat_len_q   <= pat_len_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PATTERN_BYTES:      prdata = pat_bytes_q;
			REG_PATTERN_LENGTH:     prdata = CFG_DATA_W'(pat_len_q);
			REG_REPLACEMENT_BYTES:  prdata = rep_bytes_q;
			REG_REPLACEMENT_LENGTH: prdata = CFG_DATA_W'(rep_len_q);
			default:                prdata = '0;
		endcase
	end

	// lengths saturate at the size limits
	assign pat_len = (pat_len_q > CFG_LEN_W'(MAX_PATTERN_LEN)) ?
		PW'(MAX_PATTERN_LEN) : PW'(pat_len_q);
	assign rep_len = (rep_len_q > CFG_LEN_W'(MAX_REPLACE_LEN)) ?
		RW'(MAX_REPLACE_LEN) : RW'(rep_len_q);

	// handshake control
	assign out_valid = (rem_q != '0);
	assign out_take  = out_valid && !out_stall;
	assign buf_free  = (rem_q == '0) || ((rem_q == NW'(1)) && out_take);
	assign adv       = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !buf_free;
	assign in_take   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= in_byte;
			final_s1 <= in_final;
		end
	end

	// window and match logic
	sfr_window #(
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN),
		.MAX_REPLACE_LEN (MAX_REPLACE_LEN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_byte   (byte_s1),
		.in_final  (final_s1),
		.pat_bytes (pat_bytes_q),
		.pat_len   (pat_len),
		.rep_bytes (rep_bytes_q),
		.rep_len   (rep_len),
		.res_byte  (res_byte),
		.res_n     (res_n),
		.res_has   (res_has)
	);

	// result buffer count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			has_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (adv) begin
			rem_q <= res_n;
			has_q <= res_has;
			fin_q <= final_s1;
		end else if (out_take) begin
			rem_q <= rem_q - NW'(1);
		end
	end

	// result bytes, shifted toward the head on each output transfer
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < RES_DEPTH; i++) begin
				obuf_q[i] <= res_byte[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < RES_DEPTH - 1; i++) begin
				obuf_q[i] <= obuf_q[i + 1];
			end
		end
	end

	assign out_byte   = obuf_q[0];
	assign has_byte   = has_q;
	assign run_end    = (rem_q == NW'(1));
	assign string_end = run_end && fin_q;

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= NW'(RES_DEPTH))
		else $error("result count exceeds buffer depth");

	a_marker_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> run_end && string_end)
		else $error("empty marker not the final result of a string");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the result buffer is empty");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_n != '0 |=> out_valid && rem_q == $past(res_n))
		else $error("result list not loaded into the buffer");
`endif

endmodule
`default_nettype wire
